// ===== rtl/core/cvdc_pkg.sv =====
// Shared types and constants of the calibrated voltage to DAC code block.
package cvdc_pkg;

  localparam int unsigned MV_W       = 16;
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned CODE_MAX   = (2 ** CODE_W) - 1;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned ENTRIES_W  = 7;
  localparam int unsigned DIV_W      = 2 * MV_W;
  localparam int unsigned CNT_W      = $clog2(DIV_W + 1);
  localparam int unsigned PROD_W     = MV_W + CODE_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic                 RST_COMP_EN    = 1'b1;
  localparam logic [ENTRIES_W-1:0] RST_ENTRIES    = 7'd33;
  localparam logic [MV_W-1:0]      RST_FULL_SCALE = 16'd60000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMP_EN       = 2'd0,
    CFG_TABLE_ENTRIES = 2'd1,
    CFG_FULL_SCALE    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CLAMP_LOW  = 3'd1,
    ST_CLAMP_HIGH = 3'd2,
    ST_NO_SEGMENT = 3'd3,
    ST_FLAT       = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RDL,
    S_CLAMP,
    S_WALK,
    S_MUL,
    S_DIV,
    S_SP,
    S_SCALE,
    S_SAT,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e             command;
    logic [IDX_W-1:0] entry_index;
    logic [MV_W-1:0]  entry_setpoint_mv;
    logic [MV_W-1:0]  entry_measured_mv;
    logic [MV_W-1:0]  target_mv;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] dac_code;
    status_e           status;
  } out_item_t;

  typedef struct packed {
    logic [MV_W-1:0] setpoint;
    logic [MV_W-1:0] measured;
  } entry_t;

endpackage

// ===== rtl/core/cvdc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module cvdc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/calibrated_voltage_to_dac_code.sv =====
// Top level: calibration table, segment walk, interpolation and code scaling.
//
//   channel  direction  handshake                fields
//   cfg      in         cfg_we_i                 cfg_index_i, cfg_wdata_i
//   in       in         in_valid_i / in_stall_o  in_item_i (in_item_t)
//   out      out        out_valid_o / out_stall_i out_item_o (out_item_t)
//
// A write item is one RAM write. A convert item with compensation off only
// scales (no scale division when the code saturates); with it on it first walks
// the n entries in use (one RAM read per entry) and interpolates. The divider
// makes one quotient bit per cycle: 32 bits to interpolate, 12 bits to scale.
// Reset restores config and control registers; table contents are not cleared.
// One result waits in the output register; the next convert holds in its
// last state until that register is free.
module calibrated_voltage_to_dac_code #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cvdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cvdc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cvdc_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cvdc_pkg::out_item_t                 out_item_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $bits(cvdc_pkg::entry_t);
  localparam int unsigned MW = cvdc_pkg::MV_W;
  localparam int unsigned DW = cvdc_pkg::DIV_W;
  localparam int unsigned CW = cvdc_pkg::CODE_W;
  localparam int unsigned PW = cvdc_pkg::PROD_W;
  localparam int unsigned KW = cvdc_pkg::CNT_W;

  cvdc_pkg::state_e state_q, state_d;

  logic                           comp_en_q;
  logic [cvdc_pkg::ENTRIES_W-1:0] entries_q;
  logic [MW-1:0]                  full_scale_q;

  logic                 out_valid_q, out_valid_d;
  cvdc_pkg::out_item_t  out_item_q;

  logic [MW-1:0]        mv_q, mv_d;
  cvdc_pkg::status_e    status_q, status_d;
  logic [CW-1:0]        code_q, code_d;
  logic [NW-1:0]        n_q, n_d;
  logic [AW-1:0]        seg_q, seg_d;
  logic [MW-1:0]        prev_m_q, prev_m_d;
  logic [MW-1:0]        prev_s_q, prev_s_d;
  logic [MW-1:0]        dsp_q, dsp_d;
  logic                 neg_q, neg_d;
  logic [MW-1:0]        den_q, den_d;
  logic [MW-1:0]        r_q, r_d;
  logic [DW-1:0]        dvd_q, dvd_d;
  logic [KW-1:0]        cnt_q, cnt_d;
  logic                 div_scale_q, div_scale_d;
  logic [PW-1:0]        prod_q, prod_d;

  logic                 in_acc;
  logic                 is_convert;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;
  cvdc_pkg::entry_t     wr_entry;
  cvdc_pkg::entry_t     cur;
  logic [NW-1:0]        n_clamp;
  logic                 walk_hit;
  logic                 walk_flat;
  logic                 walk_last;
  logic [MW:0]          div_shift;
  logic                 div_ge;
  logic [MW:0]          div_rem;
  logic [MW-1:0]        r_next;
  logic [DW-1:0]        dvd_next;
  logic                 sat;
  logic                 out_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_en_q    <= cvdc_pkg::RST_COMP_EN;
      entries_q    <= cvdc_pkg::RST_ENTRIES;
      full_scale_q <= cvdc_pkg::RST_FULL_SCALE;
    end else if (cfg_we_i) begin
      unique case (cvdc_pkg::cfg_reg_e'(cfg_index_i))
        cvdc_pkg::CFG_COMP_EN: begin
          comp_en_q <= cfg_wdata_i[0];
        end
        cvdc_pkg::CFG_TABLE_ENTRIES: begin
          entries_q <= cfg_wdata_i[cvdc_pkg::ENTRIES_W-1:0];
        end
        cvdc_pkg::CFG_FULL_SCALE: begin
          full_scale_q <= cfg_wdata_i[MW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = (state_q != cvdc_pkg::S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_convert = (in_item_i.command == cvdc_pkg::CMD_CONVERT);

  assign ram_we    = in_acc & ~is_convert & (32'(in_item_i.entry_index) < TABLE_DEPTH);
  assign ram_waddr = AW'(in_item_i.entry_index);
  assign wr_entry  = '{setpoint: in_item_i.entry_setpoint_mv,
                       measured: in_item_i.entry_measured_mv};

  cvdc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur = cvdc_pkg::entry_t'(ram_rdata);

  always_comb begin
    if (entries_q < cvdc_pkg::ENTRIES_W'(2)) begin
      n_clamp = NW'(2);
    end else if (32'(entries_q) > TABLE_DEPTH) begin
      n_clamp = NW'(TABLE_DEPTH);
    end else begin
      n_clamp = NW'(entries_q);
    end
  end

  always_comb begin
    unique case (state_q)
      cvdc_pkg::S_RDL:   ram_raddr = AW'(n_q - NW'(1));
      cvdc_pkg::S_CLAMP: ram_raddr = AW'(1);
      cvdc_pkg::S_WALK:  ram_raddr = seg_q + AW'(2);
      default:           ram_raddr = '0;
    endcase
  end

  assign walk_hit  = (mv_q >= prev_m_q) && (mv_q <= cur.measured);
  assign walk_flat = (cur.measured == prev_m_q);
  assign walk_last = ((NW + 1)'(seg_q) + (NW + 1)'(2)) == (NW + 1)'(n_q);

  // Restoring divider step, one quotient bit per cycle
  assign div_shift = {r_q, dvd_q[DW-1]};
  assign div_ge    = div_shift >= {1'b0, den_q};
  assign div_rem   = div_ge ? (div_shift - {1'b0, den_q}) : div_shift;
  assign r_next    = div_rem[MW-1:0];
  assign dvd_next  = {dvd_q[DW-2:0], div_ge};

  assign sat      = prod_q >= {full_scale_q, {CW{1'b0}}};
  assign out_free = ~out_valid_q | ~out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cvdc_pkg::S_IDLE: begin
        if (in_acc && is_convert) begin
          state_d = comp_en_q ? cvdc_pkg::S_RD0 : cvdc_pkg::S_SCALE;
        end
      end
      cvdc_pkg::S_RD0:   state_d = cvdc_pkg::S_RDL;
      cvdc_pkg::S_RDL:   state_d = cvdc_pkg::S_CLAMP;
      cvdc_pkg::S_CLAMP: state_d = cvdc_pkg::S_WALK;
      cvdc_pkg::S_WALK: begin
        if (walk_hit) begin
          state_d = walk_flat ? cvdc_pkg::S_SCALE : cvdc_pkg::S_MUL;
        end else if (walk_last) begin
          state_d = cvdc_pkg::S_DONE;
        end
      end
      cvdc_pkg::S_MUL: state_d = cvdc_pkg::S_DIV;
      cvdc_pkg::S_DIV: begin
        if (cnt_q == KW'(1)) begin
          state_d = div_scale_q ? cvdc_pkg::S_DONE : cvdc_pkg::S_SP;
        end
      end
      cvdc_pkg::S_SP:    state_d = cvdc_pkg::S_SCALE;
      cvdc_pkg::S_SCALE: state_d = cvdc_pkg::S_SAT;
      cvdc_pkg::S_SAT:   state_d = sat ? cvdc_pkg::S_DONE : cvdc_pkg::S_DIV;
      cvdc_pkg::S_DONE: begin
        if (out_free) begin
          state_d = cvdc_pkg::S_IDLE;
        end
      end
      default: state_d = cvdc_pkg::S_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    mv_d        = mv_q;
    status_d    = status_q;
    code_d      = code_q;
    n_d         = n_q;
    seg_d       = seg_q;
    prev_m_d    = prev_m_q;
    prev_s_d    = prev_s_q;
    dsp_d       = dsp_q;
    neg_d       = neg_q;
    den_d       = den_q;
    r_d         = r_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;
    div_scale_d = div_scale_q;
    prod_d      = prod_q;
    unique case (state_q)
      cvdc_pkg::S_IDLE: begin
        mv_d     = in_item_i.target_mv;
        status_d = cvdc_pkg::ST_OK;
        n_d      = n_clamp;
      end
      cvdc_pkg::S_RDL: begin
        prev_m_d = cur.measured;
        prev_s_d = cur.setpoint;
        seg_d    = '0;
        if (mv_q < cur.measured) begin
          mv_d     = cur.measured;
          status_d = cvdc_pkg::ST_CLAMP_LOW;
        end
      end
      cvdc_pkg::S_CLAMP: begin
        if (mv_q > cur.measured) begin
          mv_d     = cur.measured;
          status_d = cvdc_pkg::ST_CLAMP_HIGH;
        end
      end
      cvdc_pkg::S_WALK: begin
        if (walk_hit) begin
          if (walk_flat) begin
            mv_d     = prev_s_q;
            status_d = cvdc_pkg::ST_FLAT;
          end else begin
            mv_d  = mv_q - prev_m_q;
            neg_d = cur.setpoint < prev_s_q;
            dsp_d = (cur.setpoint < prev_s_q) ? (prev_s_q - cur.setpoint)
                                              : (cur.setpoint - prev_s_q);
            den_d = cur.measured - prev_m_q;
          end
        end else if (walk_last) begin
          code_d   = '0;
          status_d = cvdc_pkg::ST_NO_SEGMENT;
        end else begin
          prev_m_d = cur.measured;
          prev_s_d = cur.setpoint;
          seg_d    = seg_q + AW'(1);
        end
      end
      cvdc_pkg::S_MUL: begin
        dvd_d       = DW'(mv_q) * DW'(dsp_q);
        r_d         = '0;
        cnt_d       = KW'(DW);
        div_scale_d = 1'b0;
      end
      cvdc_pkg::S_DIV: begin
        r_d   = r_next;
        dvd_d = dvd_next;
        cnt_d = cnt_q - KW'(1);
        if ((cnt_q == KW'(1)) && div_scale_q) begin
          code_d = dvd_next[CW-1:0];
        end
      end
      cvdc_pkg::S_SP: begin
        mv_d = neg_q ? (prev_s_q - dvd_q[MW-1:0]) : (prev_s_q + dvd_q[MW-1:0]);
      end
      cvdc_pkg::S_SCALE: begin
        prod_d = PW'(mv_q) * PW'(cvdc_pkg::CODE_MAX);
      end
      cvdc_pkg::S_SAT: begin
        if (sat) begin
          code_d = CW'(cvdc_pkg::CODE_MAX);
          if (status_q == cvdc_pkg::ST_OK) begin
            status_d = cvdc_pkg::ST_CLAMP_HIGH;
          end
        end else begin
          // quotient fits CW bits, so the top bits already form the remainder
          r_d         = prod_q[PW-1:CW];
          dvd_d       = {prod_q[CW-1:0], {(DW - CW){1'b0}}};
          den_d       = full_scale_q;
          cnt_d       = KW'(CW);
          div_scale_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == cvdc_pkg::S_DONE) && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cvdc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_q        <= mv_d;
    status_q    <= status_d;
    code_q      <= code_d;
    n_q         <= n_d;
    seg_q       <= seg_d;
    prev_m_q    <= prev_m_d;
    prev_s_q    <= prev_s_d;
    dsp_q       <= dsp_d;
    neg_q       <= neg_d;
    den_q       <= den_d;
    r_q         <= r_d;
    dvd_q       <= dvd_d;
    cnt_q       <= cnt_d;
    div_scale_q <= div_scale_d;
    prod_q      <= prod_d;
    if ((state_q == cvdc_pkg::S_DONE) && out_free) begin
      out_item_q <= '{dac_code: code_q, status: status_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_div_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvdc_pkg::S_DIV) |-> (den_q != '0))
    else $error("divider running with zero divisor");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvdc_pkg::S_DIV) |-> (r_q < den_q))
    else $error("partial remainder not below divisor");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvdc_pkg::S_WALK)
      |-> (((NW + 1)'(seg_q) + (NW + 1)'(2)) <= (NW + 1)'(n_q)))
    else $error("segment walk beyond entries in use");

  a_write_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_convert) |=> (state_q == cvdc_pkg::S_IDLE))
    else $error("write item did not return to idle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == cvdc_pkg::S_DONE))
    else $error("result raised outside done state");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for calibrated_voltage_to_dac_code.
module tb;
  import cvdc_pkg::*;

  localparam int SETTLE      = 200;
  localparam int LONG_HOLD   = 400;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int NUM_ROWS    = 30;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WRITE,
    ROW_CONVERT
  } row_kind_e;

  // cfg: f0 comp, f1 entries, f2 full scale; write: f0 slot, f1 setpoint, f2 measured;
  // convert: f0 target
  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] f0;
    logic [15:0] f1;
    logic [15:0] f2;
    logic        known;
    logic [11:0] code;
    status_e     st;
  } dir_row_t;

  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_CFG,     16'd0,     16'd33,    16'd60000, 1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd0,     16'd0,     16'd0,     1'b1, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd65535, 16'd0,     16'd0,     1'b1, 12'd4095, ST_CLAMP_HIGH},
    '{ROW_CONVERT, 16'd60000, 16'd0,     16'd0,     1'b1, 12'd4095, ST_OK},
    '{ROW_CONVERT, 16'd30000, 16'd0,     16'd0,     1'b0, 12'd0,    ST_OK},
    '{ROW_CFG,     16'd0,     16'd33,    16'd0,     1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd0,     16'd0,     16'd0,     1'b1, 12'd4095, ST_CLAMP_HIGH},
    '{ROW_CFG,     16'd0,     16'd33,    16'd1,     1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd1,     16'd0,     16'd0,     1'b1, 12'd4095, ST_OK},
    '{ROW_CONVERT, 16'd2,     16'd0,     16'd0,     1'b1, 12'd4095, ST_CLAMP_HIGH},
    '{ROW_CFG,     16'd1,     16'd0,     16'd65535, 1'b0, 12'd0,    ST_OK},
    '{ROW_WRITE,   16'd0,     16'd0,     16'd1000,  1'b0, 12'd0,    ST_OK},
    '{ROW_WRITE,   16'd1,     16'd65535, 16'd2000,  1'b0, 12'd0,    ST_OK},
    '{ROW_WRITE,   16'd63,    16'd65535, 16'd65535, 1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd0,     16'd0,     16'd0,     1'b1, 12'd0,    ST_CLAMP_LOW},
    '{ROW_CONVERT, 16'd65535, 16'd0,     16'd0,     1'b1, 12'd4095, ST_CLAMP_HIGH},
    '{ROW_CONVERT, 16'd1500,  16'd0,     16'd0,     1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd1000,  16'd0,     16'd0,     1'b1, 12'd0,    ST_OK},
    '{ROW_WRITE,   16'd1,     16'd500,   16'd1000,  1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd1000,  16'd0,     16'd0,     1'b1, 12'd0,    ST_FLAT},
    '{ROW_CONVERT, 16'd7,     16'd0,     16'd0,     1'b1, 12'd0,    ST_FLAT},
    '{ROW_WRITE,   16'd0,     16'd0,     16'd3000,  1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd2000,  16'd0,     16'd0,     1'b1, 12'd0,    ST_NO_SEGMENT},
    '{ROW_WRITE,   16'd0,     16'd40000, 16'd0,     1'b0, 12'd0,    ST_OK},
    '{ROW_WRITE,   16'd1,     16'd0,     16'd65535, 1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd0,     16'd0,     16'd0,     1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd65535, 16'd0,     16'd0,     1'b1, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd32768, 16'd0,     16'd0,     1'b0, 12'd0,    ST_OK},
    '{ROW_CFG,     16'd1,     16'd1,     16'd60000, 1'b0, 12'd0,    ST_OK},
    '{ROW_CONVERT, 16'd21845, 16'd0,     16'd0,     1'b0, 12'd0,    ST_OK}
  };

  // comp, entries, full scale
  localparam int PHASE_CFG [8][3] = '{
    '{1, 64, 60000}, '{1, 127, 65535}, '{1, 2, 3000}, '{0, 64, 1},
    '{1, 33, 60000}, '{1, 100, 0},     '{0, 5, 65535}, '{1, 16, 40000}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_COMP_EN;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  calibrated_voltage_to_dac_code dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // mirror of the block state
  logic [15:0] set_tbl  [64];
  logic [15:0] meas_tbl [64];
  bit          comp_on     = 1'b1;
  logic [6:0]  entries_reg = 7'd33;
  logic [15:0] fs_reg      = 16'd60000;

  out_item_t   pending_codes [$];
  out_item_t   want_code;
  int          mismatches  = 0;
  int          items_sent  = 0;
  int          writes_sent = 0;
  int          converts_sent = 0;
  int          status_hits [5] = '{0, 0, 0, 0, 0};
  bit          offering    = 1'b0;
  bit          burst       = 1'b0;
  int          holds_asked = 0;
  int          holds_done  = 0;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int eff_entries();
    if (entries_reg < 7'd2) return 2;
    if (entries_reg > 7'd64) return 64;
    return int'(entries_reg);
  endfunction

  function automatic logic [11:0] scale_code(longint mv, inout status_e st);
    longint code;
    if (fs_reg == 16'd0) code = longint'(CODE_MAX) + 1;
    else code = (mv * longint'(CODE_MAX)) / longint'(fs_reg);
    if (code > longint'(CODE_MAX)) begin
      code = longint'(CODE_MAX);
      if (st == ST_OK) st = ST_CLAMP_HIGH;
    end
    return code[11:0];
  endfunction

  function automatic out_item_t convert_to_code(logic [15:0] target);
    longint t, m0, m1, s0, s1, sp;
    int n;
    bit found;
    status_e st;
    logic [11:0] code;
    out_item_t res;
    t = longint'(target);
    st = ST_OK;
    found = 1'b0;
    sp = 0;
    code = '0;
    if (!comp_on) begin
      code = scale_code(t, st);
    end else begin
      n = eff_entries();
      if (t < longint'(meas_tbl[0])) begin
        t = longint'(meas_tbl[0]);
        st = ST_CLAMP_LOW;
      end
      if (t > longint'(meas_tbl[n-1])) begin
        t = longint'(meas_tbl[n-1]);
        st = ST_CLAMP_HIGH;
      end
      for (int i = 0; i + 1 < n && !found; i++) begin
        m0 = longint'(meas_tbl[i]);
        m1 = longint'(meas_tbl[i+1]);
        if (t >= m0 && t <= m1) begin
          found = 1'b1;
          s0 = longint'(set_tbl[i]);
          s1 = longint'(set_tbl[i+1]);
          if (m1 == m0) begin
            sp = s0;
            st = ST_FLAT;
          end else begin
            sp = s0 + ((t - m0) * (s1 - s0)) / (m1 - m0);
          end
        end
      end
      if (!found) begin
        code = '0;
        st = ST_NO_SEGMENT;
      end else begin
        if (sp < 0) sp = 0;
        code = scale_code(sp, st);
      end
    end
    res.dac_code = code;
    res.status = st;
    return res;
  endfunction

  function automatic in_item_t mk_write(logic [5:0] idx, logic [15:0] sp, logic [15:0] meas);
    in_item_t it;
    it.command = CMD_WRITE;
    it.entry_index = idx;
    it.entry_setpoint_mv = sp;
    it.entry_measured_mv = meas;
    it.target_mv = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_convert(logic [15:0] target);
    in_item_t it;
    it.command = CMD_CONVERT;
    it.entry_index = 6'($urandom);
    it.entry_setpoint_mv = 16'($urandom);
    it.entry_measured_mv = 16'($urandom);
    it.target_mv = target;
    return it;
  endfunction

  function automatic logic [15:0] pick_target();
    int n, r;
    n = eff_entries();
    r = int'($urandom_range(0, 99));
    if (!comp_on) begin
      if (r < 50 && fs_reg != 16'd0) return 16'($urandom_range(0, 32'(fs_reg)));
      return 16'($urandom);
    end
    if (r < 65) return 16'($urandom_range(32'(meas_tbl[0]), 32'(meas_tbl[n-1])));
    if (r < 80) return meas_tbl[$urandom_range(0, n - 1)];
    if (r < 92) return 16'($urandom);
    if (r < 96) return 16'd0;
    return 16'hFFFF;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 45) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 96) return int'($urandom_range(4, 15));
    return int'($urandom_range(30, 100));
  endfunction

  task automatic offer(in_item_t it, bit typed, out_item_t typed_res);
    int gap;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (it.command == CMD_WRITE) begin
      set_tbl[it.entry_index]  = it.entry_setpoint_mv;
      meas_tbl[it.entry_index] = it.entry_measured_mv;
      writes_sent++;
    end else begin
      pending_codes.push_back(typed ? typed_res : convert_to_code(it.target_mv));
      converts_sent++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic idle_sender();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(bit comp, logic [6:0] entries, logic [15:0] fs);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_COMP_EN;
    cfg_wdata_i <= {15'd0, comp};
    @(posedge clk_i);
    cfg_index_i <= CFG_TABLE_ENTRIES;
    cfg_wdata_i <= {9'd0, entries};
    @(posedge clk_i);
    cfg_index_i <= CFG_FULL_SCALE;
    cfg_wdata_i <= fs;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    comp_on = comp;
    entries_reg = entries;
    fs_reg = fs;
  endtask

  // calibration curve over slots 0..n-1: measured mostly rising, with the odd flat or falling step
  task automatic build_profile(int n);
    int span, cur_m, cur_s, dir, step;
    span = 60000 / n;
    dir = int'($urandom_range(0, 2));
    cur_m = int'($urandom_range(0, 3000));
    cur_s = (dir == 1) ? int'($urandom_range(40000, 65535)) : int'($urandom_range(0, 5000));
    for (int i = 0; i < n; i++) begin
      offer(mk_write(6'(i), 16'(cur_s), 16'(cur_m)), 1'b0, '0);
      step = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 2 * span));
      if ($urandom_range(0, 19) == 0) step = -int'($urandom_range(1, span));
      cur_m = cur_m + step;
      cur_m = (cur_m > 65535) ? 65535 : ((cur_m < 0) ? 0 : cur_m);
      case (dir)
        0: cur_s = cur_s + int'($urandom_range(0, 2 * span));
        1: cur_s = cur_s - int'($urandom_range(0, 2 * span));
        default: cur_s = int'($urandom_range(0, 65535));
      endcase
      cur_s = (cur_s > 65535) ? 65535 : ((cur_s < 0) ? 0 : cur_s);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (out_item_o.status <= ST_FLAT) status_hits[out_item_o.status]++;
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("item with nothing pending: code %0d status %0d",
                                  out_item_o.dac_code, out_item_o.status));
      end else begin
        want_code = pending_codes.pop_front();
        if (out_item_o.dac_code !== want_code.dac_code)
          report_mismatch($sformatf("dac_code %0d, want %0d",
                                    out_item_o.dac_code, want_code.dac_code));
        if (out_item_o.status !== want_code.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_item_o.status, want_code.status));
      end
    end
  end

  initial begin : receiver
    int remain;
    bit level;
    remain = 0;
    level = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done++;
        level = 1'b1;
        remain = LONG_HOLD;
      end else if (remain == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin level = 1'b0; remain = int'($urandom_range(1, 6)); end
          4, 5, 6:    begin level = 1'b1; remain = int'($urandom_range(1, 4)); end
          7:          begin level = 1'b1; remain = int'($urandom_range(20, 80)); end
          default:    begin level = 1'b0; remain = int'($urandom_range(50, 300)); end
        endcase
      end
      remain--;
      out_stall_i <= level;
    end
  end

  initial begin : stimulus
    dir_row_t  row;
    out_item_t typed_res;
    int        phase_start, r, j;
    bit        held, paused, saved;
    held = 1'b0;
    paused = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NUM_ROWS; k++) begin
      row = DIRECTED[k];
      case (row.kind)
        ROW_CFG: begin
          idle_sender();
          wait_drained();
          set_config(row.f0[0], row.f1[6:0], row.f2);
        end
        ROW_WRITE: offer(mk_write(row.f0[5:0], row.f1, row.f2), 1'b0, '0);
        default: begin
          typed_res.dac_code = row.code;
          typed_res.status = row.st;
          offer(mk_convert(row.f0), row.known, typed_res);
        end
      endcase
    end

    build_profile(64);

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_sender();
      wait_drained();
      if (p < 8) begin
        set_config(PHASE_CFG[p][0] != 0, 7'(PHASE_CFG[p][1]), 16'(PHASE_CFG[p][2]));
      end else begin
        set_config($urandom_range(0, 3) != 0,
                   $urandom_range(0, 1) ? 7'($urandom_range(0, 12)) : 7'($urandom),
                   $urandom_range(0, 1) ? 16'($urandom_range(20000, 65535))
                                        : 16'($urandom));
      end
      burst = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      if ($urandom_range(0, 1) != 0) build_profile(eff_entries());
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (p == 2 && !held && items_sent - phase_start >= 40) begin
          // output held off while converts keep coming
          held = 1'b1;
          holds_asked++;
          saved = burst;
          burst = 1'b1;
          repeat (12) offer(mk_convert(pick_target()), 1'b0, '0);
          burst = saved;
        end
        if (p == 4 && !paused && items_sent - phase_start >= 80) begin
          paused = 1'b1;
          idle_sender();
          wait_drained();
        end
        r = int'($urandom_range(0, 99));
        if (r < 2) begin
          build_profile(eff_entries());
        end else if (r < 14) begin
          j = int'($urandom_range(0, 63));
          offer(mk_write(6'(j), 16'($urandom),
                         $urandom_range(0, 1) ? 16'($urandom) : meas_tbl[j == 0 ? 1 : j - 1]),
                1'b0, '0);
        end else begin
          offer(mk_convert(pick_target()), 1'b0, '0);
        end
      end
    end

    idle_sender();
    wait_drained();
    $display("covered %0d items: %0d table writes, %0d conversions, %0d register settings",
             items_sent, writes_sent, converts_sent, NUM_PHASES + 5);
    $display("status seen: ok %0d, clamp low %0d, clamp high %0d, no segment %0d, flat %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (mismatches == 0) begin
      $display("calibrated_voltage_to_dac_code regression: pass");
    end else begin
      $display("calibrated_voltage_to_dac_code regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("calibrated_voltage_to_dac_code regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cvdc_pkg.sv
rtl/core/cvdc_ram.sv
rtl/core/calibrated_voltage_to_dac_code.sv
dv/tb.sv
